/* hw/rtl/aliased_register_allocator_defines.svh */
// Assertion macros shared by the allocator checker.
// Needs clk_i and rst_ni visible in the including scope.
`ifndef ALIASED_REGISTER_ALLOCATOR_DEFINES_SVH
`define ALIASED_REGISTER_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define ARA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ARA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/ara_pkg.sv */
// Types and codes for the aliased register allocator.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ara_pkg;

  typedef enum logic [2:0] {
    CMD_DEFINE     = 3'd0,
    CMD_ALLOC_SIZE = 3'd1,
    CMD_ALLOC_IDX  = 3'd2,
    CMD_FREE       = 3'd3,
    CMD_SET_TAG    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_FREE   = 2'd0,
    ST_ALLOC  = 2'd1,
    ST_ALIAS  = 2'd2,
    ST_ABSENT = 2'd3
  } entry_st_e;

  typedef enum logic [1:0] {
    FSM_IDLE   = 2'd0,
    FSM_MATCH  = 2'd1,
    FSM_UPDATE = 2'd2
  } fsm_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;    // capture the input transfer
    logic eval;    // search and register the selected entry
    logic commit;  // update the table and write the result register
  } ctl_t;

  localparam int unsigned AliasBits = 16;
  localparam int unsigned CountBits = 5;

endpackage

/* hw/rtl/ara_ctrl.sv */
// Controller for the aliased register allocator: command sequencing,
// input/output handshakes and output valid. Depends on ara_pkg.
`timescale 1ns / 1ps

module ara_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output ara_pkg::ctl_t ctl_o
);
  import ara_pkg::*;

  fsm_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic can_finish;
  logic in_ready;

  assign can_finish = !out_valid_q || !out_stall_i;

  always_comb begin
    in_ready = (state_q == FSM_IDLE) || ((state_q == FSM_UPDATE) && can_finish);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) state_d = FSM_MATCH;
      end
      FSM_MATCH: begin
        state_d = FSM_UPDATE;
      end
      FSM_UPDATE: begin
        if (can_finish) state_d = in_valid_i ? FSM_MATCH : FSM_IDLE;
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl_o.load   = in_ready && in_valid_i;
    ctl_o.eval   = (state_q == FSM_MATCH);
    ctl_o.commit = (state_q == FSM_UPDATE) && can_finish;
    in_stall_o   = !in_ready;
    out_valid_d  = ctl_o.commit || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/ara_datapath.sv */
// Datapath for the aliased register allocator: register table, search,
// alias update and result register. Depends on ara_pkg.
`timescale 1ns / 1ps

module ara_datapath #(
  parameter int unsigned NUM_ENTRIES = 16,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ara_pkg::ctl_t                     ctl_i,
  input  logic                              cfg_we_i,
  input  logic [ara_pkg::CountBits-1:0]     cfg_wdata_i,
  input  logic [2:0]                        command_i,
  input  logic [3:0]                        reg_index_i,
  input  logic [7:0]                        width_code_i,
  input  logic [2:0]                        deref_level_i,
  input  logic [ara_pkg::AliasBits-1:0]     alias_mask_i,
  input  logic                              exists_i,
  input  logic [15:0]                       tag_i,
  output logic                              failed_o,
  output logic [3:0]                        granted_index_o
);
  import ara_pkg::*;

  localparam int unsigned IW = $clog2(NUM_ENTRIES);

  // Table
  entry_st_e            status_q [NUM_ENTRIES];
  entry_st_e            status_d [NUM_ENTRIES];
  logic [TAG_BITS-1:0]  etag_q   [NUM_ENTRIES];
  logic [TAG_BITS-1:0]  etag_d   [NUM_ENTRIES];
  logic [7:0]           width_q  [NUM_ENTRIES];
  logic [2:0]           level_q  [NUM_ENTRIES];
  logic [AliasBits-1:0] alias_q  [NUM_ENTRIES];

  logic [CountBits-1:0] active_q;

  // Captured command
  cmd_e           cmd_q;
  logic [3:0]     idx_q;
  logic [7:0]     wcode_q;
  logic [2:0]     lvl_q;
  logic [AliasBits-1:0] amask_q;
  logic           exists_q;
  logic [15:0]    tagin_q;

  // Search result
  logic [IW-1:0]  sel_q, sel_d;
  logic           ok_q, ok_d;

  logic                      failed_q;
  logic [3:0]                granted_q;

  logic [5:0]                act6, eff_n, lim;
  logic                      valid_idx;
  logic [IW+3:0]             idx_ext;
  logic [IW-1:0]             idx_e;
  logic [IW+3:0]             sel_ext;
  logic [NUM_ENTRIES-1:0]    scan_hit;
  logic [IW-1:0]             upd_idx;
  logic [AliasBits-1:0]      upd_mask;
  logic [NUM_ENTRIES+AliasBits-1:0] mask_ext;
  logic [NUM_ENTRIES-1:0]    alias_hit;
  logic [TAG_BITS+15:0]      tag_ext;
  logic [TAG_BITS-1:0]       tag_val;
  logic                      is_alloc;

  assign act6      = {1'b0, active_q};
  assign eff_n     = (act6 > 6'(NUM_ENTRIES)) ? 6'(NUM_ENTRIES) : act6;
  assign lim       = (eff_n > 6'd16) ? 6'd16 : eff_n;
  assign valid_idx = ({2'b00, idx_q} < 6'(NUM_ENTRIES));
  assign idx_ext   = {{IW{1'b0}}, idx_q};
  assign idx_e     = idx_ext[IW-1:0];
  assign sel_ext   = {4'b0000, sel_q};
  assign tag_ext   = {{TAG_BITS{1'b0}}, tagin_q};
  assign tag_val   = tag_ext[TAG_BITS-1:0];
  assign is_alloc  = (cmd_q == CMD_ALLOC_SIZE) || (cmd_q == CMD_ALLOC_IDX);

  // Search: lowest free entry matching width, with level >= requested.
  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      scan_hit[i] = (6'(i) < eff_n) && (status_q[i] == ST_FREE) &&
                    (width_q[i] == wcode_q) && (level_q[i] >= lvl_q);
    end
  end

  always_comb begin
    sel_d = '0;
    ok_d  = 1'b0;
    case (cmd_q)
      CMD_ALLOC_SIZE: begin
        ok_d = |scan_hit;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
          if (scan_hit[i]) sel_d = IW'(i);
        end
      end
      CMD_ALLOC_IDX: begin
        sel_d = idx_e;
        ok_d  = valid_idx && (status_q[idx_e] == ST_FREE);
      end
      default: begin
        sel_d = '0;
        ok_d  = 1'b0;
      end
    endcase
  end

  // Alias set of the addressed entry.
  assign upd_idx  = is_alloc ? sel_q : idx_e;
  assign upd_mask = alias_q[upd_idx];
  assign mask_ext = {{NUM_ENTRIES{1'b0}}, upd_mask};

  always_comb begin
    for (int b = 0; b < NUM_ENTRIES; b++) begin
      alias_hit[b] = mask_ext[b] && (6'(b) < lim) && (status_q[b] != ST_ABSENT);
    end
  end

  always_comb begin
    status_d = status_q;
    etag_d   = etag_q;
    case (cmd_q)
      CMD_DEFINE: begin
        if (valid_idx) status_d[idx_e] = exists_q ? ST_FREE : ST_ABSENT;
      end
      CMD_ALLOC_SIZE, CMD_ALLOC_IDX: begin
        if (ok_q) begin
          for (int b = 0; b < NUM_ENTRIES; b++) begin
            if (alias_hit[b]) begin
              status_d[b] = ST_ALIAS;
              etag_d[b]   = '0;
            end
          end
          if (!alias_hit[sel_q]) status_d[sel_q] = ST_ALLOC;
        end
      end
      CMD_FREE: begin
        if (valid_idx) begin
          for (int b = 0; b < NUM_ENTRIES; b++) begin
            if (alias_hit[b]) status_d[b] = ST_FREE;
          end
          status_d[idx_e] = ST_FREE;
        end
      end
      CMD_SET_TAG: begin
        if (valid_idx) begin
          for (int b = 0; b < NUM_ENTRIES; b++) begin
            if (alias_hit[b]) begin
              status_d[b] = ST_ALIAS;
              etag_d[b]   = tag_val;
            end
          end
        end
      end
      default: begin
        status_d = status_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= CountBits'(16);
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        status_q[i] <= ST_ABSENT;
        etag_q[i]   <= '0;
      end
    end else begin
      if (cfg_we_i) active_q <= cfg_wdata_i;
      if (ctl_i.commit) begin
        status_q <= status_d;
        etag_q   <= etag_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit && (cmd_q == CMD_DEFINE) && valid_idx) begin
      width_q[idx_e] <= wcode_q;
      level_q[idx_e] <= lvl_q;
      alias_q[idx_e] <= amask_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q    <= cmd_e'(command_i);
      idx_q    <= reg_index_i;
      wcode_q  <= width_code_i;
      lvl_q    <= deref_level_i;
      amask_q  <= alias_mask_i;
      exists_q <= exists_i;
      tagin_q  <= tag_i;
    end
    if (ctl_i.eval) begin
      sel_q <= sel_d;
      ok_q  <= ok_d;
    end
    if (ctl_i.commit) begin
      failed_q  <= is_alloc && !ok_q;
      granted_q <= (is_alloc && ok_q) ? sel_ext[3:0] : 4'd0;
    end
  end

  assign failed_o        = failed_q;
  assign granted_index_o = granted_q;

endmodule

/* hw/rtl/aliased_register_allocator.sv */
// Aliased register allocator, top level: controller plus datapath.
// Depends on ara_pkg, ara_ctrl and ara_datapath.
//
// Usage: commands arrive on the input channel (in_valid_i / in_stall_o),
// one result per command leaves on the output channel
// (out_valid_o / out_stall_i). A transfer happens when valid is high and
// stall is low. active_count is written through cfg_we_i / cfg_wdata_i;
// the user must write it only while the block is idle (not enforced).
// Each command passes the MATCH state, which searches the table
// (parallel width/level compare and priority pick), and then the UPDATE
// state, which applies the alias update to the flop table and loads the
// result register.
// The next command is taken in the UPDATE state of the previous one, if
// the output register is empty or its result is taken in that cycle.
// Stall: if the receiver stalls with a result pending, the update of the
// next command holds in its UPDATE state and input stalls until the
// output register frees.
// Reset: every entry is absent, tags are zero, active_count is 16, no
// result is pending.
`timescale 1ns / 1ps

module aliased_register_allocator #(
  parameter int unsigned NUM_ENTRIES = 16,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ara_pkg::CountBits-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    command_i,
  input  logic [3:0]                    reg_index_i,
  input  logic [7:0]                    width_code_i,
  input  logic [2:0]                    deref_level_i,
  input  logic [ara_pkg::AliasBits-1:0] alias_mask_i,
  input  logic                          exists_i,
  input  logic [15:0]                   tag_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          failed_o,
  output logic [3:0]                    granted_index_o
);
  import ara_pkg::*;

  ctl_t ctl;

  ara_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl)
  );

  ara_datapath #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .TAG_BITS    (TAG_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .command_i       (command_i),
    .reg_index_i     (reg_index_i),
    .width_code_i    (width_code_i),
    .deref_level_i   (deref_level_i),
    .alias_mask_i    (alias_mask_i),
    .exists_i        (exists_i),
    .tag_i           (tag_i),
    .failed_o        (failed_o),
    .granted_index_o (granted_index_o)
  );

endmodule

/* hw/rtl/ara_checker.sv */
// Port-level checks for the aliased register allocator, bound to the top.
// Depends on aliased_register_allocator_defines.svh.
`timescale 1ns / 1ps
`include "aliased_register_allocator_defines.svh"

module ara_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        failed_o,
  input logic [3:0]  granted_index_o
);

  logic [4:0] payload;

  assign payload = {failed_o, granted_index_o};

  // One command in flight: the cycle after a transfer is the search cycle.
  `ARA_ASSERT_NEXT(a_one_in_flight, in_valid_i && !in_stall_o, in_stall_o, "early transfer")

  `ARA_ASSERT_NOW(a_fail_idx, out_valid_o && failed_o, granted_index_o == 4'd0, "index on fail")

  `ARA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped")

  `ARA_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(payload), "payload changed")

endmodule

bind aliased_register_allocator ara_checker u_ara_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .failed_o        (failed_o),
  .granted_index_o (granted_index_o)
);

/* tb/tb_top.sv */
// Self-checking testbench for aliased_register_allocator.
// Tracks the register table in a local shadow model and compares every result transfer.
// Depends on ara_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module tb_top;
  import ara_pkg::*;

  localparam int unsigned NumEntries    = 16;
  localparam int unsigned CmdSpareFirst = CMD_SET_TAG + 1;
  localparam int unsigned CmdSpareLast  = 7;
  localparam int unsigned CycleLimit    = 400000;

  typedef struct {
    logic [2:0]  command;
    logic [3:0]  reg_index;
    logic [7:0]  width_code;
    logic [2:0]  deref_level;
    logic [15:0] alias_mask;
    logic        exists;
    logic [15:0] tag;
  } alloc_cmd_t;

  typedef struct {
    logic       failed;
    logic [3:0] granted_index;
  } alloc_reply_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CountBits-1:0] cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [2:0]           command_i = '0;
  logic [3:0]           reg_index_i = '0;
  logic [7:0]           width_code_i = '0;
  logic [2:0]           deref_level_i = '0;
  logic [AliasBits-1:0] alias_mask_i = '0;
  logic                 exists_i = 1'b0;
  logic [15:0]          tag_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 failed_o;
  logic [3:0]           granted_index_o;

  // shadow of the register table
  entry_st_e            tbl_status  [NumEntries];
  logic [7:0]           tbl_width   [NumEntries];
  logic [2:0]           tbl_level   [NumEntries];
  logic [15:0]          tbl_aliases [NumEntries];
  logic [15:0]          tbl_tag     [NumEntries];
  bit                   tbl_defined [NumEntries];
  logic [CountBits-1:0] tbl_count;

  alloc_reply_t reply_q[$];
  int           err_cnt = 0;
  int           sink_hold_cycles = 0;
  bit           no_idle = 1'b0;

  logic [7:0] common_widths [4] = '{8'h08, 8'h10, 8'h20, 8'h40};

  always #10 clk_i = ~clk_i;

  aliased_register_allocator #(
    .NUM_ENTRIES(NumEntries),
    .TAG_BITS   (16)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .reg_index_i    (reg_index_i),
    .width_code_i   (width_code_i),
    .deref_level_i  (deref_level_i),
    .alias_mask_i   (alias_mask_i),
    .exists_i       (exists_i),
    .tag_i          (tag_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .failed_o       (failed_o),
    .granted_index_o(granted_index_o)
  );

  function automatic void mark_overlaps(input int unsigned e, input bit with_self,
                                        input entry_st_e st, input bit write_tag,
                                        input logic [15:0] t);
    int unsigned span;
    span = (tbl_count > NumEntries) ? NumEntries : tbl_count;
    for (int unsigned b = 0; b < span; b++) begin
      if (!with_self && b == e) continue;
      if (!tbl_aliases[e][b]) continue;
      if (tbl_status[b] == ST_ABSENT) continue;
      tbl_status[b] = st;
      if (write_tag) tbl_tag[b] = t;
    end
  endfunction

  function automatic void grant_entry(input int unsigned e);
    tbl_status[e] = ST_ALLOC;
    mark_overlaps(e, 1'b0, ST_ALIAS, 1'b0, '0);
    mark_overlaps(e, 1'b1, ST_ALIAS, 1'b1, '0);
  endfunction

  // Applies one command to the shadow table and returns the expected reply.
  function automatic alloc_reply_t table_apply(input alloc_cmd_t c);
    alloc_reply_t rep;
    int unsigned  scan_n;
    int           hit;
    rep.failed = 1'b0;
    rep.granted_index = '0;
    case (c.command)
      CMD_DEFINE: begin
        tbl_width[c.reg_index]   = c.width_code;
        tbl_level[c.reg_index]   = c.deref_level;
        tbl_aliases[c.reg_index] = c.alias_mask;
        tbl_status[c.reg_index]  = c.exists ? ST_FREE : ST_ABSENT;
        tbl_defined[c.reg_index] = 1'b1;
      end
      CMD_ALLOC_SIZE: begin
        scan_n = (tbl_count > NumEntries) ? NumEntries : tbl_count;
        hit = -1;
        for (int unsigned i = 0; i < scan_n; i++) begin
          if (tbl_status[i] == ST_FREE && tbl_width[i] == c.width_code &&
              tbl_level[i] >= c.deref_level) begin
            hit = i;
            break;
          end
        end
        if (hit >= 0) begin
          grant_entry(hit);
          rep.granted_index = hit[3:0];
        end else begin
          rep.failed = 1'b1;
        end
      end
      CMD_ALLOC_IDX: begin
        if (tbl_status[c.reg_index] == ST_FREE) begin
          grant_entry(c.reg_index);
          rep.granted_index = c.reg_index;
        end else begin
          rep.failed = 1'b1;
        end
      end
      CMD_FREE: begin
        tbl_status[c.reg_index] = ST_FREE;
        mark_overlaps(c.reg_index, 1'b0, ST_FREE, 1'b0, '0);
      end
      CMD_SET_TAG: begin
        mark_overlaps(c.reg_index, 1'b1, ST_ALIAS, 1'b1, c.tag);
      end
      default: ;
    endcase
    return rep;
  endfunction

  function automatic alloc_cmd_t mk_cmd(input logic [2:0] cmd, input logic [3:0] idx,
                                        input logic [7:0] w, input logic [2:0] lvl,
                                        input logic [15:0] m, input logic ex,
                                        input logic [15:0] t);
    alloc_cmd_t c;
    c.command = cmd;
    c.reg_index = idx;
    c.width_code = w;
    c.deref_level = lvl;
    c.alias_mask = m;
    c.exists = ex;
    c.tag = t;
    return c;
  endfunction

  function automatic logic [7:0] pick_width();
    if ($urandom_range(0, 9) < 8) return common_widths[$urandom_range(0, 3)];
    return 8'($urandom);
  endfunction

  // Mostly well-formed traffic; free and set tag only touch entries that were defined.
  function automatic alloc_cmd_t random_cmd();
    alloc_cmd_t  c;
    int unsigned sel;
    int unsigned live[$];
    logic [15:0] own;
    c = mk_cmd(3'($urandom), 4'($urandom), 8'($urandom), 3'($urandom), 16'($urandom),
               1'($urandom), 16'($urandom));
    for (int unsigned i = 0; i < NumEntries; i++) if (tbl_defined[i]) live.push_back(i);
    sel = $urandom_range(0, 99);
    if (live.size() == 0 && sel >= 70) sel = 0;
    if (sel < 16) begin
      c.command = CMD_DEFINE;
      c.width_code = pick_width();
      c.exists = ($urandom_range(0, 6) != 0);
      own = 16'(1) << c.reg_index;
      case ($urandom_range(0, 3))
        0: c.alias_mask = 16'($urandom);
        1: c.alias_mask = own;
        default: c.alias_mask = ($urandom_range(0, 1) ? own : 16'h0) |
                                (16'(1) << $urandom_range(0, 15)) |
                                (16'(1) << $urandom_range(0, 15));
      endcase
    end else if (sel < 46) begin
      c.command = CMD_ALLOC_SIZE;
      c.width_code = pick_width();
      c.deref_level = 3'($urandom_range(0, $urandom_range(0, 7)));
    end else if (sel < 66) begin
      c.command = CMD_ALLOC_IDX;
    end else if (sel < 70) begin
      c.command = 3'($urandom_range(CmdSpareFirst, CmdSpareLast));
    end else begin
      c.command = (sel < 90) ? CMD_FREE : CMD_SET_TAG;
      c.reg_index = 4'(live[$urandom_range(0, live.size() - 1)]);
    end
    return c;
  endfunction

  task automatic send_cmd(input alloc_cmd_t c);
    in_valid_i    <= 1'b1;
    command_i     <= c.command;
    reg_index_i   <= c.reg_index;
    width_code_i  <= c.width_code;
    deref_level_i <= c.deref_level;
    alias_mask_i  <= c.alias_mask;
    exists_i      <= c.exists;
    tag_i         <= c.tag;
    do @(posedge clk_i); while (in_stall_o);
    reply_q.push_back(table_apply(c));
  endtask

  task automatic sender_gap();
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_active_count(input logic [CountBits-1:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tbl_count = v;
  endtask

  task automatic run_random(input int unsigned n);
    repeat (n) begin
      send_cmd(random_cmd());
      sender_gap();
    end
  endtask

  task automatic test_directed();
    send_cmd(mk_cmd(CMD_DEFINE, 4'd0, 8'h20, 3'd3, 16'h0003, 1'b1, 16'h0000));
    send_cmd(mk_cmd(CMD_DEFINE, 4'd1, 8'h20, 3'd7, 16'h0003, 1'b1, 16'hFFFF));
    send_cmd(mk_cmd(CMD_DEFINE, 4'd15, 8'hFF, 3'd7, 16'hFFFF, 1'b1, 16'h0000));
    send_cmd(mk_cmd(CMD_DEFINE, 4'd2, 8'h00, 3'd0, 16'h0000, 1'b0, 16'h0000));
    send_cmd(mk_cmd(CMD_ALLOC_SIZE, 4'd0, 8'h20, 3'd5, 16'h0000, 1'b0, 16'h0000));
    send_cmd(mk_cmd(CMD_ALLOC_SIZE, 4'd15, 8'h20, 3'd0, 16'hFFFF, 1'b1, 16'hFFFF));
    send_cmd(mk_cmd(CMD_ALLOC_IDX, 4'd0, 8'h00, 3'd0, 16'h0000, 1'b0, 16'h0000));
    send_cmd(mk_cmd(CMD_FREE, 4'd1, 8'h00, 3'd0, 16'h0000, 1'b0, 16'h0000));
    send_cmd(mk_cmd(CMD_ALLOC_IDX, 4'd0, 8'h00, 3'd0, 16'h0000, 1'b0, 16'h0000));
    send_cmd(mk_cmd(CMD_SET_TAG, 4'd15, 8'h00, 3'd0, 16'h0000, 1'b0, 16'hFFFF));
    send_cmd(mk_cmd(CMD_ALLOC_SIZE, 4'd0, 8'hFF, 3'd7, 16'h0000, 1'b0, 16'h0000));
    send_cmd(mk_cmd(CMD_FREE, 4'd15, 8'h00, 3'd0, 16'h0000, 1'b0, 16'h0000));
    send_cmd(mk_cmd(CMD_ALLOC_SIZE, 4'd0, 8'hFF, 3'd7, 16'h0000, 1'b0, 16'h0000));
    send_cmd(mk_cmd(CMD_ALLOC_IDX, 4'd2, 8'h00, 3'd0, 16'h0000, 1'b0, 16'h0000));
    // freeing an absent entry makes it free
    send_cmd(mk_cmd(CMD_FREE, 4'd2, 8'h00, 3'd0, 16'h0000, 1'b0, 16'h0000));
    send_cmd(mk_cmd(CMD_ALLOC_SIZE, 4'd0, 8'h00, 3'd0, 16'h0000, 1'b0, 16'h0000));
    for (int unsigned k = CmdSpareFirst; k <= CmdSpareLast; k++)
      send_cmd(mk_cmd(3'(k), 4'hF, 8'hFF, 3'd7, 16'hFFFF, 1'b1, 16'hFFFF));
    send_cmd(mk_cmd(CMD_DEFINE, 4'd15, 8'hFF, 3'd7, 16'hFFFF, 1'b0, 16'h0000));
    send_cmd(mk_cmd(CMD_ALLOC_IDX, 4'd15, 8'h00, 3'd0, 16'h0000, 1'b0, 16'h0000));
    send_cmd(mk_cmd(CMD_SET_TAG, 4'd0, 8'h00, 3'd0, 16'h0000, 1'b0, 16'h5A5A));
  endtask

  task automatic test_random_traffic();
    run_random(700);
  endtask

  task automatic test_active_count();
    logic [CountBits-1:0] counts [6] = '{5'd0, 5'd1, 5'd31, 5'd17, 5'd7, 5'd16};
    foreach (counts[i]) begin
      set_active_count(counts[i]);
      run_random(30);
    end
  endtask

  task automatic test_backpressure();
    sink_hold_cycles = 200;
    repeat (12) send_cmd(random_cmd());
    wait_idle();
  endtask

  task automatic test_no_idle();
    no_idle = 1'b1;
    run_random(100);
  endtask

  task automatic check_reply();
    alloc_reply_t e;
    if (reply_q.size() == 0) begin
      $error("unexpected transfer: failed=%0d granted_index=%0d", failed_o, granted_index_o);
      err_cnt++;
    end else begin
      e = reply_q.pop_front();
      if (failed_o !== e.failed) begin
        $error("failed: expected %0d, actual %0d", e.failed, failed_o);
        err_cnt++;
      end
      if (granted_index_o !== e.granted_index) begin
        $error("granted_index: expected %0d, actual %0d", e.granted_index, granted_index_o);
        err_cnt++;
      end
    end
  endtask

  initial begin : reply_sink
    int  stall_run;
    bit  stalled;
    stall_run = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) check_reply();
      if (sink_hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        sink_hold_cycles--;
      end else if (no_idle) begin
        out_stall_i <= 1'b0;
      end else if (stall_run > 0) begin
        stall_run--;
      end else begin
        stalled = ($urandom_range(0, 2) == 0);
        out_stall_i <= stalled;
        stall_run = stalled ? $urandom_range(0, 15) : $urandom_range(0, 23);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    for (int unsigned i = 0; i < NumEntries; i++) begin
      tbl_status[i]  = ST_ABSENT;
      tbl_width[i]   = '0;
      tbl_level[i]   = '0;
      tbl_aliases[i] = '0;
      tbl_tag[i]     = '0;
      tbl_defined[i] = 1'b0;
    end
    tbl_count = 5'd16;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic();
    test_active_count();
    test_backpressure();
    test_no_idle();

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
